// ===== rtl/psm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package psm_pkg;

  localparam int NUM_CHANNELS_DEF     = 4;
  localparam int SAMPLE_ADDR_BITS_DEF = 16;

  localparam int RATE_W = 17;
  localparam int POS_W  = 24;
  localparam int FLD_W  = 16;

  localparam logic [RATE_W-1:0] RATE_RESET = 17'd22050;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_WRITE    = 3'd1,
    ACT_PLAY     = 3'd2,
    ACT_STOP     = 3'd3,
    ACT_VOLUME   = 3'd4,
    ACT_STOP_ALL = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_VOL_WB,
    ST_CH_RD,
    ST_CH_EVAL,
    ST_RD_B2,
    ST_MUL1,
    ST_MUL2,
    ST_SCALE,
    ST_ACCUM,
    ST_OUT
  } state_t;

  // one channel-memory word
  typedef struct packed {
    logic [7:0]       volume;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] step;
    logic [FLD_W-1:0] base;
    logic [FLD_W-1:0] length;
    logic [FLD_W-1:0] loop_start;
    logic [FLD_W-1:0] loop_length;
  } chan_rec_t;

endpackage
`default_nettype wire

// ===== rtl/pcm_sample_mixer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Handshake          | Carries
// in      | in_valid/in_ready  | action, channel, sample_addr, sample_byte, freq,
//         |                    | volume, length, loop_start, loop_length
// out     | out_valid/out_ready| mixed_sample, active_mask (one item per tick)
// cfg     | cfg_we             | cfg_wdata -> output_rate
//
// Write, stop and stop-all complete in ST_IDLE; set volume is a word read-modify-write
// (ST_VOL_WB); play waits in ST_DIV on the serial divider. A tick is a serial walk
// over channel and sample memory; a channel that ends on it skips the sample reads.
// Reset clears control state, active bits and output_rate (22050); memories
// are not cleared. A finished tick waits in ST_OUT while the output register
// is still full; in_ready is low whenever an item is in progress.
module pcm_sample_mixer_unit #(
  parameter int NUM_CHANNELS     = psm_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_ADDR_BITS = psm_pkg::SAMPLE_ADDR_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        action,
  input  wire logic [1:0]        channel,
  input  wire logic [15:0]       sample_addr,
  input  wire logic signed [7:0] sample_byte,
  input  wire logic [15:0]       freq,
  input  wire logic [7:0]        volume,
  input  wire logic [15:0]       length,
  input  wire logic [15:0]       loop_start,
  input  wire logic [15:0]       loop_length,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             mixed_sample,
  output logic [3:0]             active_mask,
  input  wire logic              cfg_we,
  input  wire logic [psm_pkg::RATE_W-1:0] cfg_wdata
);
  import psm_pkg::*;

  localparam int CIW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int IDXW     = $clog2(NUM_CHANNELS + 1);
  localparam int SM_DEPTH = 1 << SAMPLE_ADDR_BITS;
  localparam int SUMW     = (SAMPLE_ADDR_BITS > 18) ? SAMPLE_ADDR_BITS : 18;

  state_t state, state_next;

  logic [RATE_W-1:0]       rate;
  logic [NUM_CHANNELS-1:0] active;
  logic [IDXW-1:0]         idx;
  logic [CIW-1:0]          idx_c;
  logic                    accept, ch_ok, idx_end;
  action_t                 act;

  // channel memory
  chan_rec_t ch_mem [NUM_CHANNELS];
  chan_rec_t ch_q, ch_wd, rec_new;
  logic      ch_we, ch_re;
  logic [CIW-1:0] ch_addr;

  // sample memory
  logic [7:0] sm_mem [SM_DEPTH];
  logic [7:0] sm_q;
  logic       sm_we;
  logic [SAMPLE_ADDR_BITS-1:0] sm_addr;

  // captured play item
  logic [CIW-1:0]   cap_ch;
  logic [7:0]       cap_vol;
  logic [FLD_W-1:0] cap_base, cap_len, cap_ls, cap_ll;

  // divider
  logic             div_start, div_done;
  logic [POS_W-1:0] div_q;

  // per-channel datapath
  logic [7:0]         frac;
  logic [16:0]        p2;
  logic [7:0]         vol_r;
  logic [FLD_W-1:0]   base_r;
  logic signed [7:0]  b1, b2;
  logic signed [16:0] prod1, mixsum, scaled_p;
  logic signed [7:0]  acc;

  // evaluation of the fetched channel word
  logic [FLD_W-1:0] p1;
  logic [POS_W-1:0] pos_new;
  logic [16:0]      p2_w, lend;
  logic [FLD_W-1:0] end_w;
  logic             has_loop, loop_hit, stop_hit;

  // accumulate
  logic signed [16:0] biased;
  logic signed [10:0] scl;
  logic signed [11:0] sum12;
  logic signed [7:0]  acc_next;
  logic               out_load;

  assign accept = in_valid && in_ready;
  assign act    = action_t'(action);
  assign ch_ok  = (32'(channel) < NUM_CHANNELS);
  assign idx_c  = idx[CIW-1:0];
  assign idx_end = (idx == IDXW'(NUM_CHANNELS));
  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  function automatic logic [SAMPLE_ADDR_BITS-1:0] smaddr(input logic [15:0] b,
                                                        input logic [16:0] off);
    logic [SUMW-1:0] s;
    s = SUMW'(b) + SUMW'(off);
    return s[SAMPLE_ADDR_BITS-1:0];
  endfunction

  psm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({freq, 8'h00}),
    .divisor  (rate),
    .done     (div_done),
    .quotient (div_q)
  );

  // loop / end decisions on the word read from channel memory
  always_comb begin
    p1       = ch_q.position[POS_W-1:8];
    has_loop = (ch_q.loop_length != '0);
    lend     = {1'b0, ch_q.loop_start} + {1'b0, ch_q.loop_length} - 17'd1;
    loop_hit = has_loop && ({1'b0, p1} >= lend);
    end_w    = (ch_q.length != '0) ? ch_q.length - 16'd1 : '0;
    stop_hit = !has_loop && (p1 >= end_w);
    pos_new  = loop_hit ? {ch_q.loop_start, 8'h00} : ch_q.position + ch_q.step;
    p2_w     = loop_hit ? {1'b0, ch_q.loop_start} : {1'b0, p1} + 17'd1;
  end

  // new channel word for play
  always_comb begin
    rec_new.volume      = cap_vol;
    rec_new.position    = '0;
    rec_new.step        = div_q;
    rec_new.base        = cap_base;
    rec_new.length      = cap_len;
    rec_new.loop_start  = cap_ls;
    rec_new.loop_length = cap_ll;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (act)
            ACT_TICK:   state_next = ST_CH_RD;
            ACT_PLAY:   state_next = ch_ok ? ST_DIV : ST_IDLE;
            ACT_VOLUME: state_next = ch_ok ? ST_VOL_WB : ST_IDLE;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIV:     state_next = div_done ? ST_IDLE : ST_DIV;
      ST_VOL_WB:  state_next = ST_IDLE;
      ST_CH_RD: begin
        if (idx_end) begin
          state_next = ST_OUT;
        end else if (active[idx_c]) begin
          state_next = ST_CH_EVAL;
        end
      end
      ST_CH_EVAL: state_next = stop_hit ? ST_CH_RD : ST_RD_B2;
      ST_RD_B2:   state_next = ST_MUL1;
      ST_MUL1:    state_next = ST_MUL2;
      ST_MUL2:    state_next = ST_SCALE;
      ST_SCALE:   state_next = ST_ACCUM;
      ST_ACCUM:   state_next = ST_CH_RD;
      ST_OUT:     state_next = out_load ? ST_IDLE : ST_OUT;
      default:    state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    ch_we     = 1'b0;
    ch_re     = 1'b0;
    ch_addr   = idx_c;
    ch_wd     = ch_q;
    sm_we     = 1'b0;
    sm_addr   = smaddr(sample_addr, 17'd0);
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ch_addr = CIW'(channel);
        if (accept && act == ACT_VOLUME && ch_ok) ch_re = 1'b1;
        if (accept && act == ACT_WRITE) sm_we = 1'b1;
        if (accept && act == ACT_PLAY && ch_ok) div_start = 1'b1;
      end
      ST_DIV: begin
        ch_addr = cap_ch;
        ch_wd   = rec_new;
        ch_we   = div_done;
      end
      ST_VOL_WB: begin
        ch_addr      = cap_ch;
        ch_wd.volume = cap_vol;
        ch_we        = 1'b1;
      end
      ST_CH_RD: begin
        ch_re = !idx_end && active[idx_c];
      end
      ST_CH_EVAL: begin
        ch_wd.position = pos_new;
        ch_we          = !stop_hit;
        sm_addr        = smaddr(ch_q.base, {1'b0, p1});
      end
      ST_RD_B2: begin
        sm_addr = smaddr(base_r, p2);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ch_we) ch_mem[ch_addr] <= ch_wd;
    if (ch_re) ch_q <= ch_mem[ch_addr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) sm_mem[sm_addr] <= sample_byte;
    sm_q <= sm_mem[sm_addr];
  end

  // scale truncates toward zero, then saturating add
  always_comb begin
    biased = scaled_p + (scaled_p[16] ? 17'sd63 : 17'sd0);
    scl    = $signed(biased[16:6]);
    sum12  = $signed({{4{acc[7]}}, acc}) + $signed({scl[10], scl});
    if (sum12 > 12'sd127) begin
      acc_next = 8'sd127;
    end else if (sum12 < -12'sd128) begin
      acc_next = -8'sd128;
    end else begin
      acc_next = sum12[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= '0;
      rate      <= RATE_RESET;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) rate <= cfg_wdata;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (act)
              ACT_STOP:     if (ch_ok) active[CIW'(channel)] <= 1'b0;
              ACT_STOP_ALL: active <= '0;
              default: begin
              end
            endcase
          end
          idx <= '0;
        end
        ST_DIV:     if (div_done) active[cap_ch] <= 1'b1;
        ST_CH_RD:   if (!idx_end && !active[idx_c]) idx <= idx + IDXW'(1);
        ST_CH_EVAL: if (stop_hit) begin
          active[idx_c] <= 1'b0;
          idx           <= idx + IDXW'(1);
        end
        ST_ACCUM:   idx <= idx + IDXW'(1);
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      cap_ch   <= CIW'(channel);
      cap_vol  <= volume;
      cap_base <= sample_addr;
      cap_len  <= length;
      cap_ls   <= loop_start;
      cap_ll   <= loop_length;
      acc      <= '0;
    end
    if (state == ST_CH_EVAL) begin
      frac   <= ch_q.position[7:0];
      p2     <= p2_w;
      vol_r  <= ch_q.volume;
      base_r <= ch_q.base;
    end
    if (state == ST_RD_B2) b1 <= $signed(sm_q);
    if (state == ST_MUL1) begin
      b2    <= $signed(sm_q);
      prod1 <= b1 * $signed({1'b0, ~frac});
    end
    if (state == ST_MUL2) mixsum <= prod1 + b2 * $signed({1'b0, frac});
    if (state == ST_SCALE) scaled_p <= $signed(mixsum[15:8]) * $signed({1'b0, vol_r});
    if (state == ST_ACCUM) acc <= acc_next;
    if (out_load) begin
      mixed_sample <= {~acc[7], acc[6:0]};
      for (int i = 0; i < 4; i++) begin
        active_mask[i] <= (i < NUM_CHANNELS) ? active[i % NUM_CHANNELS] : 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/psm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle
module psm_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [psm_pkg::POS_W-1:0]   dividend,
  input  wire logic [psm_pkg::RATE_W-1:0]  divisor,
  output logic                             done,
  output logic [psm_pkg::POS_W-1:0]        quotient
);
  import psm_pkg::*;

  localparam int CNT_W = $clog2(POS_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RATE_W-1:0] rem;
  logic [RATE_W-1:0] dvs;
  logic [RATE_W:0]   trial;
  logic              qbit;

  always_comb begin
    trial = {rem, quotient[POS_W-1]};
    qbit  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        quotient <= dividend;
        dvs      <= (divisor == '0) ? RATE_W'(1) : divisor;
      end else if (busy) begin
        rem      <= qbit ? RATE_W'(trial - {1'b0, dvs}) : trial[RATE_W-1:0];
        quotient <= {quotient[POS_W-2:0], qbit};
        cnt      <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(POS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire
